// File: rtl/nsmf_pkg.sv
// Package: shared widths, request mode codes and flag encodings for the n-gram set filter.
package nsmf_pkg;

   localparam int KEY_BYTES_DEF = 2;

   localparam int MODE_W     = 3;
   localparam int QUERY_W    = 16;
   localparam int TOTAL_W    = 18;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_COMPARE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TEST      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_INTERSECT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EXCLUDE   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd5;

   localparam logic [1:0] FLAG_NONE    = 2'b00;
   localparam logic [1:0] FLAG_PRESENT = 2'b01;
   localparam logic [1:0] FLAG_SEEN    = 2'b10;

endpackage

// File: rtl/ngram_set_mark_filter.sv
// N-gram set filter: flag store and group-live memories with a two-stage read-modify-write path.
// Insert, compare, test and unused requests: one accepted per cycle while idle and the output is
//   not stalled; the response comes from a registered memory read, then the output register.
// Intersect, exclude and count: a sweep over all 2^(8*KEY_BYTES) keys through the single read
//   port, with no new request taken meanwhile.
// Reset: synchronous; afterwards a clearing pass over all 2^(8*KEY_BYTES) keys writes both
//   memories to zero while req_tready stays low.
module ngram_set_mark_filter #(
   parameter int KEY_BYTES = nsmf_pkg::KEY_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] data_byte, [8] buffer_start, [24:9] query_key, [31:25] zero
   input  logic [nsmf_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] mode
   input  logic [nsmf_pkg::MODE_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] hit, [1] set_empty, [19:2] flag_total, [20] acted, [23:21] zero
   output logic [nsmf_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int KEY_BITS    = 8 * KEY_BYTES;
   localparam int WIN_BITS    = KEY_BITS - 8;
   localparam int STORE_DEPTH = 1 << KEY_BITS;
   localparam int GRP_DEPTH   = 1 << WIN_BITS;
   localparam int TW          = nsmf_pkg::TOTAL_W;
   localparam int MW          = nsmf_pkg::MODE_W;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_RUN    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [KEY_BITS-1:0] KEY_LAST = {KEY_BITS{1'b1}};

   // memories
   logic [1:0] flag_mem [STORE_DEPTH];
   logic       grp_mem  [GRP_DEPTH];

   // control and datapath registers
   logic [1:0]          state_ff, state_in;
   logic [KEY_BITS-1:0] sw_addr_ff, sw_addr_in;
   logic                sw_issued_ff, sw_issued_in;
   logic                p_valid_ff, p_valid_in;
   logic [KEY_BITS-1:0] p_addr_ff, p_addr_in;
   logic [MW-1:0]       sw_op_ff, sw_op_in;
   logic                live_acc_ff, live_acc_in;
   logic                any_acc_ff, any_acc_in;
   logic [TW-1:0]       total_ff, total_in;
   logic [WIN_BITS-1:0] win_ff, win_in;
   logic [1:0]          fill_ff, fill_in;
   logic                s1_valid_ff, s1_valid_in;
   logic [MW-1:0]       s1_mode_ff, s1_mode_in;
   logic [KEY_BITS-1:0] s1_key_ff, s1_key_in;
   logic                s1_act_ff, s1_act_in;
   logic [1:0]          rd_flag_ff;
   logic                rd_live_ff;
   logic                fwd_f_ff, fwd_f_in;
   logic [1:0]          fwd_fd_ff, fwd_fd_in;
   logic                fwd_g_ff, fwd_g_in;
   logic                fwd_gd_ff, fwd_gd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [nsmf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // combinational
   logic                req_accept;
   logic                out_free;
   logic [MW-1:0]       mode_req;
   logic [7:0]          data_req;
   logic                start_req;
   logic [nsmf_pkg::QUERY_W-1:0] query_req;
   logic                is_stream;
   logic                is_sweep;
   logic [WIN_BITS-1:0] win_eff;
   logic [1:0]          fill_eff;
   logic                win_full;
   logic [KEY_BITS-1:0] shift_key;
   logic [KEY_BITS-1:0] key_req;
   logic                s1_fire;
   logic                sw_issue;
   logic [KEY_BITS-1:0] rd_addr;
   logic [WIN_BITS-1:0] rd_gaddr;
   logic [1:0]          cur_f;
   logic                cur_live;
   logic                keep;
   logic [1:0]          pop;
   logic                f_we;
   logic [KEY_BITS-1:0] f_waddr;
   logic [1:0]          f_wdata;
   logic                g_we;
   logic [WIN_BITS-1:0] g_waddr;
   logic                g_wdata;
   logic                s1_hit;
   logic                fin_empty;
   logic [TW-1:0]       fin_total;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      req_tready = (state_ff == ST_IDLE) && (!s1_valid_ff || out_free);
      req_accept = req_tvalid && req_tready;

      mode_req  = req_tuser;
      data_req  = req_tdata[7:0];
      start_req = req_tdata[8];
      query_req = req_tdata[24:9];

      is_stream = (mode_req == nsmf_pkg::MODE_INSERT) || (mode_req == nsmf_pkg::MODE_COMPARE);
      is_sweep  = (mode_req == nsmf_pkg::MODE_INTERSECT) ||
                  (mode_req == nsmf_pkg::MODE_EXCLUDE) ||
                  (mode_req == nsmf_pkg::MODE_COUNT);

      // buffer start empties the window before the new byte enters
      win_eff   = start_req ? '0 : win_ff;
      fill_eff  = start_req ? 2'd0 : fill_ff;
      win_full  = fill_eff >= 2'(KEY_BYTES - 1);
      shift_key = {win_eff, data_req};
      key_req   = (mode_req == nsmf_pkg::MODE_TEST) ? KEY_BITS'(query_req) : shift_key;

      s1_fire  = s1_valid_ff && out_free;
      sw_issue = (state_ff == ST_RUN) && !s1_valid_ff && !sw_issued_ff;

      // stalled stage 1 re-reads its own entry so the read data stays current
      if (req_accept) begin
         rd_addr = key_req;
      end else if (state_ff == ST_RUN) begin
         rd_addr = sw_addr_ff;
      end else begin
         rd_addr = s1_key_ff;
      end
      rd_gaddr = rd_addr[KEY_BITS-1:8];

      cur_f    = fwd_f_ff ? fwd_fd_ff : rd_flag_ff;
      cur_live = fwd_g_ff ? fwd_gd_ff : rd_live_ff;

      if (sw_op_ff == nsmf_pkg::MODE_INTERSECT) begin
         keep = cur_f[0] && cur_f[1];
      end else begin
         keep = cur_f[0] && !cur_f[1];
      end
      pop = {1'b0, cur_f[0]} + {1'b0, cur_f[1]};

      f_we    = 1'b0;
      f_waddr = s1_key_ff;
      f_wdata = cur_f;
      g_we    = 1'b0;
      g_waddr = s1_key_ff[KEY_BITS-1:8];
      g_wdata = 1'b1;
      if (state_ff == ST_CLEAR) begin
         f_we    = 1'b1;
         f_waddr = sw_addr_ff;
         f_wdata = nsmf_pkg::FLAG_NONE;
         g_we    = 1'b1;
         g_waddr = sw_addr_ff[KEY_BITS-1:8];
         g_wdata = 1'b0;
      end else if (p_valid_ff) begin
         if (sw_op_ff != nsmf_pkg::MODE_COUNT) begin
            f_we    = 1'b1;
            f_waddr = p_addr_ff;
            f_wdata = keep ? nsmf_pkg::FLAG_PRESENT : nsmf_pkg::FLAG_NONE;
            // close the group on its last key
            g_we    = p_addr_ff[7:0] == 8'hFF;
            g_waddr = p_addr_ff[KEY_BITS-1:8];
            g_wdata = live_acc_ff || keep;
         end
      end else if (s1_fire && s1_act_ff) begin
         if (s1_mode_ff == nsmf_pkg::MODE_INSERT) begin
            f_we    = 1'b1;
            f_wdata = cur_f | nsmf_pkg::FLAG_PRESENT;
            g_we    = 1'b1;
         end else begin
            f_we    = cur_live;
            f_wdata = cur_f | nsmf_pkg::FLAG_SEEN;
         end
      end

      // forward a write that lands on the entry being read in the same cycle
      fwd_f_in  = f_we && (f_waddr == rd_addr);
      fwd_fd_in = f_wdata;
      fwd_g_in  = g_we && (g_waddr == rd_gaddr);
      fwd_gd_in = g_wdata;

      s1_hit    = (s1_mode_ff == nsmf_pkg::MODE_TEST) && cur_live && cur_f[0];
      fin_empty = (sw_op_ff != nsmf_pkg::MODE_COUNT) && !any_acc_ff;
      fin_total = (sw_op_ff == nsmf_pkg::MODE_COUNT) ? total_ff : '0;

      // defaults: hold, except for the valid flags and the sweep read address
      state_in     = state_ff;
      sw_addr_in   = sw_addr_ff;
      sw_issued_in = sw_issued_ff;
      p_valid_in   = 1'b0;
      p_addr_in    = sw_addr_ff;
      sw_op_in     = sw_op_ff;
      live_acc_in  = live_acc_ff;
      any_acc_in   = any_acc_ff;
      total_in     = total_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      s1_valid_in  = s1_fire ? 1'b0 : s1_valid_ff;
      s1_mode_in   = s1_mode_ff;
      s1_key_in    = s1_key_ff;
      s1_act_in    = s1_act_ff;
      rsp_valid_in = rsp_tvalid && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, s1_act_ff, {TW{1'b0}}, 1'b0, s1_hit};
      end

      case (state_ff)
         ST_CLEAR: begin
            sw_addr_in = sw_addr_ff + 1'b1;
            if (sw_addr_ff == KEY_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (is_sweep) begin
                  state_in     = ST_RUN;
                  sw_addr_in   = '0;
                  sw_issued_in = 1'b0;
                  sw_op_in     = mode_req;
                  live_acc_in  = 1'b0;
                  any_acc_in   = 1'b0;
                  total_in     = '0;
               end else begin
                  s1_valid_in = 1'b1;
                  s1_mode_in  = mode_req;
                  s1_key_in   = key_req;
                  s1_act_in   = is_stream && win_full;
                  if (is_stream) begin
                     win_in = shift_key[WIN_BITS-1:0];
                     if (!win_full) begin
                        fill_in = fill_eff + 2'd1;
                     end else begin
                        fill_in = fill_eff;
                     end
                  end
               end
            end
         end
         ST_RUN: begin
            if (sw_issue) begin
               sw_addr_in = sw_addr_ff + 1'b1;
               p_valid_in = 1'b1;
               p_addr_in  = sw_addr_ff;
               if (sw_addr_ff == KEY_LAST) begin
                  sw_issued_in = 1'b1;
               end
            end
            if (p_valid_ff) begin
               live_acc_in = (p_addr_ff[7:0] == 8'hFF) ? 1'b0 : (live_acc_ff || keep);
               any_acc_in  = any_acc_ff || keep;
               total_in    = total_ff + TW'(pop);
               if (p_addr_ff == KEY_LAST) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, 1'b0, fin_total, fin_empty, 1'b0};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // flag store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (f_we) begin
         flag_mem[f_waddr] <= f_wdata;
      end
      rd_flag_ff <= flag_mem[rd_addr];
   end

   // group live bits
   always_ff @(posedge clock) begin
      if (g_we) begin
         grp_mem[g_waddr] <= g_wdata;
      end
      rd_live_ff <= grp_mem[rd_gaddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sw_addr_ff   <= '0;
         sw_issued_ff <= 1'b0;
         p_valid_ff   <= 1'b0;
         win_ff       <= '0;
         fill_ff      <= 2'd0;
         s1_valid_ff  <= 1'b0;
         fwd_f_ff     <= 1'b0;
         fwd_g_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_addr_ff   <= sw_addr_in;
         sw_issued_ff <= sw_issued_in;
         p_valid_ff   <= p_valid_in;
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_f_ff     <= fwd_f_in;
         fwd_g_ff     <= fwd_g_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_addr_ff   <= p_addr_in;
      sw_op_ff    <= sw_op_in;
      live_acc_ff <= live_acc_in;
      any_acc_ff  <= any_acc_in;
      total_ff    <= total_in;
      s1_mode_ff  <= s1_mode_in;
      s1_key_ff   <= s1_key_in;
      s1_act_ff   <= s1_act_in;
      fwd_fd_ff   <= fwd_fd_in;
      fwd_gd_ff   <= fwd_gd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sweep and the stream stage never share the memory port
   a_sweep_excl: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> !s1_valid_ff)
      else $error("sweep read overlaps a stage-1 request");

   a_sweep_state: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff |-> (state_ff == ST_RUN))
      else $error("sweep data outside a sweep");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (state_ff == ST_IDLE))
      else $error("request taken outside idle");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && !s1_valid_ff))
      else $error("activity during clearing pass");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("sweep result not delivered");

endmodule
